// ----- rtl/iso_ts_pkg.sv -----
// ----------------------------------------------------------------------------
// iso_ts_pkg
// Shared types and constants of the ISO 8601 timestamp checker.
// ----------------------------------------------------------------------------
package iso_ts_pkg;

    typedef enum logic [2:0] {
        STATUS_VALID  = 3'd0,
        STATUS_FORMAT = 3'd1,
        STATUS_ZONE   = 3'd2,
        STATUS_MONTH  = 3'd3,
        STATUS_DAY    = 3'd4,
        STATUS_HOUR   = 3'd5,
        STATUS_MINUTE = 3'd6,
        STATUS_SECOND = 3'd7
    } status_t;

    localparam int POS_W = 5;

    localparam logic [POS_W-1:0] POS_ZONE  = 5'd19;
    localparam logic [POS_W-1:0] POS_COLON = 5'd22;
    localparam logic [POS_W-1:0] LEN_SHORT = 5'd20;
    localparam logic [POS_W-1:0] LEN_LONG  = 5'd25;
    localparam logic [POS_W-1:0] POS_SAT   = 5'd26;

    localparam logic [6:0] MAX_MINUTE = 7'd59;
    localparam logic [6:0] MAX_HOUR   = 7'd23;
    localparam logic [6:0] MAX_MONTH  = 7'd12;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_T     = 8'h54;
    localparam logic [7:0] CHAR_Z     = 8'h5A;

    localparam logic [4:0] MONTH_DAYS [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // Everything the back end needs to resolve one finished string.
    typedef struct packed {
        logic [POS_W-1:0] len;
        logic [15:0]      year_bcd;
        logic [6:0]       month;
        logic [6:0]       day;
        logic [6:0]       hour;
        logic [6:0]       minute;
        logic [6:0]       second;
        logic [6:0]       zone_hour;
        logic [6:0]       zone_minute;
        logic             separator_bad;
        logic             body_digit_bad;
        logic             zone_digit_bad;
        logic             zulu_seen;
        logic             zone_sign_ok;
        logic             zone_colon_ok;
    } record_t;

endpackage

// ----- rtl/iso_ts_front.sv -----
// ----------------------------------------------------------------------------
// iso_ts_front
// Takes one character per cycle while ready, tracks its position, accumulates
// digit groups and separator flags, and pushes a record on the last character.
// ----------------------------------------------------------------------------
module iso_ts_front
    import iso_ts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    input  logic [7:0] char_code,
    input  logic       end_of_string,
    output logic       char_ready,
    output logic       rec_push,
    output record_t    rec_data,
    input  logic       rec_full
);

    record_t cur_reg;
    record_t cur_next;
    logic    is_digit;
    logic [3:0] digit;
    logic    accept;

    function automatic logic [6:0] acc7(input logic [6:0] v, input logic [3:0] d);
        acc7 = 7'(v * 7'd10 + {3'b000, d});
    endfunction

    assign is_digit   = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    assign digit      = char_code[3:0];
    assign char_ready = !rec_full;
    assign accept     = char_valid && !rec_full;

    always_comb
    begin
        cur_next = cur_reg;
        if (cur_reg.len < POS_SAT)
        begin
            cur_next.len = cur_reg.len + 5'd1;
            case (cur_reg.len) inside
                5'd0, 5'd1, 5'd2, 5'd3:
                begin
                    if (is_digit) cur_next.year_bcd = {cur_reg.year_bcd[11:0], digit};
                    else cur_next.body_digit_bad = 1'b1;
                end
                5'd5, 5'd6:
                begin
                    if (is_digit) cur_next.month = acc7(cur_reg.month, digit);
                    else cur_next.body_digit_bad = 1'b1;
                end
                5'd8, 5'd9:
                begin
                    if (is_digit) cur_next.day = acc7(cur_reg.day, digit);
                    else cur_next.body_digit_bad = 1'b1;
                end
                5'd11, 5'd12:
                begin
                    if (is_digit) cur_next.hour = acc7(cur_reg.hour, digit);
                    else cur_next.body_digit_bad = 1'b1;
                end
                5'd14, 5'd15:
                begin
                    if (is_digit) cur_next.minute = acc7(cur_reg.minute, digit);
                    else cur_next.body_digit_bad = 1'b1;
                end
                5'd17, 5'd18:
                begin
                    if (is_digit) cur_next.second = acc7(cur_reg.second, digit);
                    else cur_next.body_digit_bad = 1'b1;
                end
                5'd20, 5'd21:
                begin
                    if (is_digit) cur_next.zone_hour = acc7(cur_reg.zone_hour, digit);
                    else cur_next.zone_digit_bad = 1'b1;
                end
                5'd23, 5'd24:
                begin
                    if (is_digit) cur_next.zone_minute = acc7(cur_reg.zone_minute, digit);
                    else cur_next.zone_digit_bad = 1'b1;
                end
                5'd4, 5'd7:
                begin
                    if (char_code != CHAR_DASH) cur_next.separator_bad = 1'b1;
                end
                5'd10:
                begin
                    if (char_code != CHAR_T) cur_next.separator_bad = 1'b1;
                end
                5'd13, 5'd16:
                begin
                    if (char_code != CHAR_COLON) cur_next.separator_bad = 1'b1;
                end
                POS_ZONE:
                begin
                    cur_next.zulu_seen    = (char_code == CHAR_Z);
                    cur_next.zone_sign_ok = (char_code == CHAR_PLUS) ||
                                            (char_code == CHAR_DASH);
                end
                POS_COLON:
                begin
                    cur_next.zone_colon_ok = (char_code == CHAR_COLON);
                end
                default:
                begin
                end
            endcase
        end
    end

    // The record carries the last character's own update.
    assign rec_push = accept && end_of_string;
    assign rec_data = cur_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= '0;
        end
        else if (accept)
        begin
            if (end_of_string) cur_reg <= '0;
            else cur_reg <= cur_next;
        end
    end

endmodule

// ----- rtl/iso_ts_fifo.sv -----
// ----------------------------------------------------------------------------
// iso_ts_fifo
// Short record queue that decouples the character front end from the
// status back end.
// ----------------------------------------------------------------------------
module iso_ts_fifo
    import iso_ts_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  record_t push_data,
    output logic    full,
    input  logic    pop,
    output record_t pop_data,
    output logic    empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    record_t            entries [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1)) ptr_inc = '0;
        else ptr_inc = p + PTR_W'(1);
    endfunction

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entries[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push) entries[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push) wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop) rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (do_push && !do_pop) count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push) count_reg <= count_reg - CNT_W'(1);
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("record queue count exceeds its depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("front end pushed into a full record queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("back end popped an empty record queue");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("record queue count did not drop after a lone transfer out");

endmodule

// ----- rtl/iso_ts_back.sv -----
// ----------------------------------------------------------------------------
// iso_ts_back
// Resolves one finished string into a status code in the fixed check order
// and holds it in the output register until it is taken.
// ----------------------------------------------------------------------------
module iso_ts_back
    import iso_ts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       format_select,
    input  record_t    rec_data,
    input  logic       rec_empty,
    output logic       rec_pop,
    output logic       empty,
    input  logic       pop,
    output logic [2:0] check_status
);

    status_t status_reg;
    status_t status_next;
    logic    out_valid_reg;
    logic    load;

    // Leap year from the four year digits: the last two decide divisibility
    // by 4 and 100, the first two decide divisibility by 400.
    function automatic logic leap_year(input logic [15:0] bcd);
        logic yy_mod4;
        logic cc_mod4;
        logic yy_zero;
        yy_mod4 = (2'({bcd[4], 1'b0} + bcd[1:0]) == 2'd0);
        cc_mod4 = (2'({bcd[12], 1'b0} + bcd[9:8]) == 2'd0);
        yy_zero = (bcd[7:0] == 8'h00);
        leap_year = (yy_mod4 && !yy_zero) || (yy_zero && cc_mod4);
    endfunction

    function automatic status_t evaluate(input logic fmt, input record_t r);
        logic [POS_W-1:0] len;
        logic [4:0]       mdays;
        logic [3:0]       midx;
        len   = r.len;
        midx  = 4'(r.month - 7'd1);
        mdays = (midx < 4'd12) ? MONTH_DAYS[midx] : 5'd31;
        if ((r.month == 7'd2) && leap_year(r.year_bcd)) mdays = 5'd29;
        if (fmt) evaluate = STATUS_FORMAT;
        else if (len < LEN_SHORT || len > LEN_LONG || r.separator_bad)
            evaluate = STATUS_FORMAT;
        else if (len == LEN_SHORT && !r.zulu_seen) evaluate = STATUS_ZONE;
        else
        begin
            // A Z in the zone position ends the string if len <= LEN_LONG.
            if (r.zulu_seen) len = LEN_SHORT;
            if (len == LEN_LONG && (!r.zone_colon_ok || !r.zone_sign_ok))
                evaluate = STATUS_ZONE;
            else if (len != LEN_SHORT && len != LEN_LONG) evaluate = STATUS_ZONE;
            else if (r.body_digit_bad) evaluate = STATUS_FORMAT;
            else if (len == LEN_LONG && r.zone_digit_bad) evaluate = STATUS_ZONE;
            else if (r.month == 7'd0 || r.month > MAX_MONTH) evaluate = STATUS_MONTH;
            else if (r.day == 7'd0 || r.day > {2'b00, mdays}) evaluate = STATUS_DAY;
            else if (r.second > MAX_MINUTE) evaluate = STATUS_SECOND;
            else if (r.minute > MAX_MINUTE) evaluate = STATUS_MINUTE;
            else if (r.hour > MAX_HOUR) evaluate = STATUS_HOUR;
            else if (len == LEN_LONG &&
                     (r.zone_minute > MAX_MINUTE || r.zone_hour > MAX_HOUR))
                evaluate = STATUS_ZONE;
            else evaluate = STATUS_VALID;
        end
    endfunction

    assign status_next  = evaluate(format_select, rec_data);
    assign load         = !rec_empty && (!out_valid_reg || pop);
    assign rec_pop      = load;
    assign empty        = !out_valid_reg;
    assign check_status = status_reg;

    always_ff @(posedge clk)
    begin
        if (load) status_reg <= status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

// ----- rtl/iso8601_timestamp_checker_core.sv -----
// ----------------------------------------------------------------------------
// iso8601_timestamp_checker_core
// Checks YYYY-MM-DDThh:mm:ss timestamps with a Z or +hh:mm / -hh:mm zone,
// one character at a time, and gives one status per string.
// ----------------------------------------------------------------------------
//   Channel   Handshake            Payload
//   input     push / full          char_code[7:0], end_of_string
//   result    empty / pop          check_status[2:0]
//   config    cfg_valid/cfg_ready  cfg_data (format_select)
//
// One character is taken every cycle while full is low; the front end needs
// a single position decode and digit accumulate per character. A status
// passes the record queue, then the output register. full rises only when
// the record queue holds FIFO_DEPTH strings and the output register is still
// waiting to be taken. Reset clears the position count, the flags, the queue
// and the output valid flag, but not the status itself; format_select is 0.
// ----------------------------------------------------------------------------
module iso8601_timestamp_checker_core
    import iso_ts_pkg::*;
#(
    parameter int FIFO_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] char_code,
    input  logic       end_of_string,
    output logic       empty,
    input  logic       pop,
    output logic [2:0] check_status,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);

    logic    format_select_reg;
    logic    char_ready;
    logic    rec_push;
    record_t rec_in;
    logic    rec_full;
    logic    rec_pop;
    record_t rec_out;
    logic    rec_empty;

    assign cfg_ready = 1'b1;
    assign full      = !char_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_select_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            format_select_reg <= cfg_data;
        end
    end

    iso_ts_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .char_valid    (push),
        .char_code     (char_code),
        .end_of_string (end_of_string),
        .char_ready    (char_ready),
        .rec_push      (rec_push),
        .rec_data      (rec_in),
        .rec_full      (rec_full)
    );

    iso_ts_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rec_push),
        .push_data (rec_in),
        .full      (rec_full),
        .pop       (rec_pop),
        .pop_data  (rec_out),
        .empty     (rec_empty)
    );

    iso_ts_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .format_select (format_select_reg),
        .rec_data      (rec_out),
        .rec_empty     (rec_empty),
        .rec_pop       (rec_pop),
        .empty         (empty),
        .pop           (pop),
        .check_status  (check_status)
    );

endmodule
